[src/awf_pkg.sv]
// Shared operation codes and status types for the ALU with flags.
`default_nettype none

package awf_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_AND = 4'd2,
    OP_OR  = 4'd3,
    OP_XOR = 4'd4,
    OP_NOT = 4'd5,
    OP_SHL = 4'd6,
    OP_SHR = 4'd7,
    OP_INC = 4'd8,
    OP_DEC = 4'd9,
    OP_CMP = 4'd10
  } awf_op_t;

  typedef struct packed {
    logic carry;
    logic overflow;
  } awf_status_t;

endpackage

`default_nettype wire

[src/awf_prep.sv]
// Stage 1: decode and adder operand preparation.
`default_nettype none

module awf_prep #(
  parameter int WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         func,
  input  wire logic [WIDTH-1:0]   operand_a,
  input  wire logic [WIDTH-1:0]   operand_b,
  input  wire logic               carry_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output awf_pkg::awf_op_t        op,
  output logic [WIDTH-1:0]        a,
  output logic [WIDTH-1:0]        b,
  output logic [WIDTH-1:0]        add_b,
  output logic                    add_cin
);

  awf_pkg::awf_op_t   op_in;
  logic [WIDTH-1:0]   add_b_next;
  logic               add_cin_next;

  assign op_in    = awf_pkg::awf_op_t'(func);
  assign in_ready = !out_valid || out_ready;

  // Fold sub/inc/dec onto the single adder of the next stage.
  always_comb begin
    unique case (op_in)
      awf_pkg::OP_SUB: begin
        add_b_next   = ~operand_b;
        add_cin_next = 1'b1;
      end
      awf_pkg::OP_INC: begin
        add_b_next   = '0;
        add_cin_next = 1'b1;
      end
      awf_pkg::OP_DEC: begin
        add_b_next   = '1;
        add_cin_next = 1'b0;
      end
      default: begin
        add_b_next   = operand_b;
        add_cin_next = carry_in;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op      <= op_in;
      a       <= operand_a;
      b       <= operand_b;
      add_b   <= add_b_next;
      add_cin <= add_cin_next;
    end
  end

endmodule

`default_nettype wire

[src/awf_exec.sv]
// Stage 2: adder, logic, shift and compare, result select.
`default_nettype none

module awf_exec #(
  parameter int WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire awf_pkg::awf_op_t   op,
  input  wire logic [WIDTH-1:0]   a,
  input  wire logic [WIDTH-1:0]   b,
  input  wire logic [WIDTH-1:0]   add_b,
  input  wire logic               add_cin,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [WIDTH-1:0]        result,
  output awf_pkg::awf_status_t    status
);

  logic [WIDTH:0]       sum;
  logic [WIDTH-1:0]     result_next;
  awf_pkg::awf_status_t status_next;
  logic                 add_ovf;

  assign in_ready = !out_valid || out_ready;
  assign sum      = {1'b0, a} + {1'b0, add_b} + {{WIDTH{1'b0}}, add_cin};
  // add_b already holds ~B for subtract, so one rule covers both.
  assign add_ovf  = (a[WIDTH-1] == add_b[WIDTH-1]) && (a[WIDTH-1] != sum[WIDTH-1]);

  always_comb begin
    result_next = a;
    status_next = '0;
    unique case (op)
      awf_pkg::OP_ADD, awf_pkg::OP_SUB: begin
        result_next          = sum[WIDTH-1:0];
        status_next.carry    = sum[WIDTH];
        status_next.overflow = add_ovf;
      end
      awf_pkg::OP_INC, awf_pkg::OP_DEC: begin
        result_next       = sum[WIDTH-1:0];
        status_next.carry = sum[WIDTH];
      end
      awf_pkg::OP_AND: result_next = a & b;
      awf_pkg::OP_OR:  result_next = a | b;
      awf_pkg::OP_XOR: result_next = a ^ b;
      awf_pkg::OP_NOT: result_next = ~a;
      awf_pkg::OP_SHL: begin
        result_next       = {a[WIDTH-2:0], 1'b0};
        status_next.carry = a[WIDTH-1];
      end
      awf_pkg::OP_SHR: begin
        result_next       = {1'b0, a[WIDTH-1:1]};
        status_next.carry = a[0];
      end
      awf_pkg::OP_CMP: begin
        result_next      = '0;
        result_next[1:0] = {a < b, a > b};
      end
      default: result_next = a;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result <= result_next;
      status <= status_next;
    end
  end

endmodule

`default_nettype wire

[src/awf_flags.sv]
// Stage 3: zero and negative flags, output register.
`default_nettype none

module awf_flags #(
  parameter int WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [WIDTH-1:0]     result,
  input  wire awf_pkg::awf_status_t status,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [WIDTH-1:0]          result_word,
  output logic                      carry_out,
  output logic                      overflow_flag,
  output logic                      zero_flag,
  output logic                      negative_flag
);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      result_word   <= result;
      carry_out     <= status.carry;
      overflow_flag <= status.overflow;
      zero_flag     <= ~|result;
      negative_flag <= result[WIDTH-1];
    end
  end

endmodule

`default_nettype wire

[src/alu_with_flags_unit.sv]
// Top level of the pipelined integer ALU with status flags.
`default_nettype none

// Integer ALU, three register stages: operand prep (sub/inc/dec folded onto
// the adder inputs), execute (one WIDTH+1 bit adder, logic, shifts, unsigned
// compare) and flags (zero, negative) into the output register. An item can
// be accepted every cycle while out_ready is held high; it then moves through
// the prep, exec and flags registers. Each stage carries its own valid bit
// and takes a new item whenever it is empty or its content moves on, so
// bubbles are squeezed out and in_ready stays high while an earlier result
// waits, until all three stages are full. in_ready is combinational from
// out_ready through the stage valid bits. No state between items; reset only
// clears the valid bits. Compare puts A>B in bit 0 and A<B in bit 1; codes
// 11 to 15 pass operand_a with carry and overflow cleared.
module alu_with_flags_unit #(
  parameter int WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         func,
  input  wire logic [WIDTH-1:0]   operand_a,
  input  wire logic [WIDTH-1:0]   operand_b,
  input  wire logic               carry_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [WIDTH-1:0]        result_word,
  output logic                    carry_out,
  output logic                    overflow_flag,
  output logic                    zero_flag,
  output logic                    negative_flag
);

  // prep -> exec
  logic                 s1_valid;
  logic                 s1_ready;
  awf_pkg::awf_op_t     s1_op;
  logic [WIDTH-1:0]     s1_a;
  logic [WIDTH-1:0]     s1_b;
  logic [WIDTH-1:0]     s1_add_b;
  logic                 s1_add_cin;

  // exec -> flags
  logic                 s2_valid;
  logic                 s2_ready;
  logic [WIDTH-1:0]     s2_result;
  awf_pkg::awf_status_t s2_status;

  awf_prep #(.WIDTH(WIDTH)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .carry_in  (carry_in),
    .out_valid (s1_valid),
    .out_ready (s1_ready),
    .op        (s1_op),
    .a         (s1_a),
    .b         (s1_b),
    .add_b     (s1_add_b),
    .add_cin   (s1_add_cin)
  );

  awf_exec #(.WIDTH(WIDTH)) u_exec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (s1_ready),
    .op        (s1_op),
    .a         (s1_a),
    .b         (s1_b),
    .add_b     (s1_add_b),
    .add_cin   (s1_add_cin),
    .out_valid (s2_valid),
    .out_ready (s2_ready),
    .result    (s2_result),
    .status    (s2_status)
  );

  awf_flags #(.WIDTH(WIDTH)) u_flags (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s2_valid),
    .in_ready      (s2_ready),
    .result        (s2_result),
    .status        (s2_status),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_word   (result_word),
    .carry_out     (carry_out),
    .overflow_flag (overflow_flag),
    .zero_flag     (zero_flag),
    .negative_flag (negative_flag)
  );

endmodule

`default_nettype wire

[src/awf_checker.sv]
// Port-level assertions for the ALU with flags, bound to the top level.
`default_nettype none

module awf_checker #(
  parameter int WIDTH = 16
) (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [WIDTH-1:0] result_word,
  input wire logic             zero_flag,
  input wire logic             negative_flag
);

  // Zero flag agrees with the word it is delivered with.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (zero_flag == (result_word == '0)))
    else $error("zero_flag does not match result_word");

  // Negative flag is the top bit of the delivered word.
  a_neg: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (negative_flag == result_word[WIDTH-1]))
    else $error("negative_flag does not match result_word");

  // With the output register empty the whole pipe can take an item.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_word))
    else $error("stalled result changed");

endmodule

bind alu_with_flags_unit awf_checker #(.WIDTH(WIDTH)) u_awf_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .result_word   (result_word),
  .zero_flag     (zero_flag),
  .negative_flag (negative_flag)
);

`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for the integer ALU with status flags.
`timescale 1ns / 100ps

module tb;

  localparam int W = 16;

  // Codes 11..15 are unused and pass operand_a through.
  localparam logic [3:0] OP_PASS_FIRST = 4'd11;
  localparam logic [3:0] OP_PASS_LAST  = 4'd15;

  // Compare outcome bits in the result word.
  localparam int CMP_GT_BIT = 0;
  localparam int CMP_LT_BIT = 1;

  // Cycles to let pass after the last result; the pipe is three stages deep.
  localparam int DRAIN_CYCLES = 8;
  // Length of the receiver hold-off that backs the pipe up into in_ready.
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int RANDOM_PER_PHASE = 105;
  localparam int PRESSURE_ITEMS = 30;

  // One result item: word plus carry, overflow, zero, negative.
  typedef struct packed {
    logic [W-1:0] word;
    logic         carry;
    logic         ovf;
    logic         zero;
    logic         neg;
  } alu_flags_t;

  // One stimulus row. When typed is low, want is ignored and the predictor
  // supplies the expected item instead.
  typedef struct packed {
    logic [3:0]   op;
    logic [W-1:0] a;
    logic [W-1:0] b;
    logic         cin;
    logic         typed;
    alu_flags_t   want;
  } op_row_t;

  // Tail of a row whose expectation comes from the predictor.
  localparam logic [W+4:0] PREDICTED = '0;

  localparam int NUM_DIRECTED = 26;

  // Directed rows: op, a, b, carry_in, then either a typed expectation
  // (1, word, carry, overflow, zero, negative) or PREDICTED.
  localparam op_row_t DIRECTED_OPS [NUM_DIRECTED] = '{
    // add: zero, unsigned wrap, signed overflow both ways, carry_in on top
    {awf_pkg::OP_ADD, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0},
    {awf_pkg::OP_ADD, 16'hFFFF, 16'h0001, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0},
    {awf_pkg::OP_ADD, 16'h7FFF, 16'h0001, 1'b0, 1'b1, 16'h8000, 1'b0, 1'b1, 1'b0, 1'b1},
    {awf_pkg::OP_ADD, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b1},
    {awf_pkg::OP_ADD, 16'h8000, 16'h8000, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b1, 1'b1, 1'b0},
    // sub: carry_in must be ignored; carry is no-borrow
    {awf_pkg::OP_SUB, 16'h0000, 16'h0001, 1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b1},
    {awf_pkg::OP_SUB, 16'h8000, 16'h0001, 1'b0, 1'b1, 16'h7FFF, 1'b1, 1'b1, 1'b0, 1'b0},
    {awf_pkg::OP_SUB, 16'h1234, 16'h1234, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0},
    // logic ops clear carry and overflow even with carry_in set
    {awf_pkg::OP_AND, 16'hFFFF, 16'h0F0F, 1'b1, 1'b1, 16'h0F0F, 1'b0, 1'b0, 1'b0, 1'b0},
    {awf_pkg::OP_OR,  16'hA5C3, 16'h1248, 1'b1, PREDICTED},
    {awf_pkg::OP_XOR, 16'hAAAA, 16'h5555, 1'b0, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b1},
    {awf_pkg::OP_NOT, 16'h0000, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b1},
    {awf_pkg::OP_NOT, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0},
    // shifts: zero fill, shifted-out bit lands in carry
    {awf_pkg::OP_SHL, 16'h8001, 16'h0000, 1'b1, 1'b1, 16'h0002, 1'b1, 1'b0, 1'b0, 1'b0},
    {awf_pkg::OP_SHL, 16'h4000, 16'hFFFF, 1'b0, 1'b1, 16'h8000, 1'b0, 1'b0, 1'b0, 1'b1},
    {awf_pkg::OP_SHR, 16'h8001, 16'h0000, 1'b1, 1'b1, 16'h4000, 1'b1, 1'b0, 1'b0, 1'b0},
    {awf_pkg::OP_SHR, 16'h0001, 16'hFFFF, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0},
    // inc wraps with carry, never flags overflow; dec carry is no-borrow
    {awf_pkg::OP_INC, 16'hFFFF, 16'h0000, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0},
    {awf_pkg::OP_INC, 16'h7FFF, 16'h0000, 1'b1, 1'b1, 16'h8000, 1'b0, 1'b0, 1'b0, 1'b1},
    {awf_pkg::OP_DEC, 16'h0000, 16'h0000, 1'b0, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b1},
    {awf_pkg::OP_DEC, 16'h0001, 16'hFFFF, 1'b1, 1'b1, 16'h0000, 1'b1, 1'b0, 1'b1, 1'b0},
    // unsigned compare: greater, less, equal
    {awf_pkg::OP_CMP, 16'hFFFF, 16'h0000, 1'b0, 1'b1, 16'h0001, 1'b0, 1'b0, 1'b0, 1'b0},
    {awf_pkg::OP_CMP, 16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h0002, 1'b0, 1'b0, 1'b0, 1'b0},
    {awf_pkg::OP_CMP, 16'h5A5A, 16'h5A5A, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b1, 1'b0},
    // unused codes pass A with carry and overflow cleared
    {OP_PASS_FIRST, 16'h8000, 16'hFFFF, 1'b1,
     1'b1, 16'h8000, 1'b0, 1'b0, 1'b0, 1'b1},
    {OP_PASS_LAST, 16'h1234, 16'hBEEF, 1'b1, PREDICTED}
  };

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         in_valid = 1'b0;
  logic         in_ready;
  logic [3:0]   func = '0;
  logic [W-1:0] operand_a = '0;
  logic [W-1:0] operand_b = '0;
  logic         carry_in = 1'b0;
  logic         out_valid;
  logic         out_ready = 1'b0;
  logic [W-1:0] result_word;
  logic         carry_out;
  logic         overflow_flag;
  logic         zero_flag;
  logic         negative_flag;

  alu_flags_t pending_results[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int items_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;

  alu_with_flags_unit #(.WIDTH(W)) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .operand_a     (operand_a),
    .operand_b     (operand_b),
    .carry_in      (carry_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_word   (result_word),
    .carry_out     (carry_out),
    .overflow_flag (overflow_flag),
    .zero_flag     (zero_flag),
    .negative_flag (negative_flag)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #200000;
    $display("*** FAILED ***");
    $finish;
  end

  // Expected item for one operation: arithmetic modulo 2^W, flags from the
  // final word. Only add and sub can raise overflow.
  function automatic alu_flags_t alu_predict(logic [3:0] op, logic [W-1:0] a,
                                             logic [W-1:0] b, logic cin);
    alu_flags_t r;
    logic [W:0] sum;
    r = '0;
    sum = '0;
    case (op)
      awf_pkg::OP_ADD: begin
        sum = {1'b0, a} + {1'b0, b} + cin;
        r.word = sum[W-1:0];
        r.carry = sum[W];
        r.ovf = (a[W-1] == b[W-1]) && (a[W-1] != r.word[W-1]);
      end
      awf_pkg::OP_SUB: begin
        sum = {1'b0, a} + {1'b0, ~b} + 1'b1;
        r.word = sum[W-1:0];
        r.carry = sum[W];
        r.ovf = (a[W-1] != b[W-1]) && (a[W-1] != r.word[W-1]);
      end
      awf_pkg::OP_AND: r.word = a & b;
      awf_pkg::OP_OR:  r.word = a | b;
      awf_pkg::OP_XOR: r.word = a ^ b;
      awf_pkg::OP_NOT: r.word = ~a;
      awf_pkg::OP_SHL: begin
        r.word = {a[W-2:0], 1'b0};
        r.carry = a[W-1];
      end
      awf_pkg::OP_SHR: begin
        r.word = {1'b0, a[W-1:1]};
        r.carry = a[0];
      end
      awf_pkg::OP_INC: begin
        sum = {1'b0, a} + 1'b1;
        r.word = sum[W-1:0];
        r.carry = sum[W];
      end
      awf_pkg::OP_DEC: begin
        r.word = a - 1'b1;
        r.carry = |a;
      end
      awf_pkg::OP_CMP: begin
        r.word[CMP_GT_BIT] = a > b;
        r.word[CMP_LT_BIT] = a < b;
      end
      default: r.word = a;
    endcase
    r.zero = (r.word == '0);
    r.neg = r.word[W-1];
    return r;
  endfunction

  // Operands lean on the corners: zero, all ones, sign boundary.
  function automatic logic [W-1:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(W-1){1'b0}}};
      3: return {1'b0, {(W-1){1'b1}}};
      default: return W'($urandom);
    endcase
  endfunction

  // Offer one item, idling first at the current sender rate, and hold it
  // until the handshake. Called right after a rising edge.
  task automatic send_op(op_row_t row);
    alu_flags_t expected;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= row.op;
    operand_a <= row.a;
    operand_b <= row.b;
    carry_in  <= row.cin;
    do @(posedge clk); while (!(in_valid && in_ready));
    expected = row.typed ? row.want : alu_predict(row.op, row.a, row.b, row.cin);
    pending_results.insert(pending_results.size(), expected);
    items_sent++;
  endtask

  task automatic send_random(int count);
    op_row_t row;
    for (int i = 0; i < count; i++) begin
      row = '0;
      // Mostly real operations, a slice of unused codes.
      if ($urandom_range(0, 9) < 8)
        row.op = 4'($urandom_range(int'(awf_pkg::OP_ADD), int'(awf_pkg::OP_CMP)));
      else
        row.op = 4'($urandom_range(int'(OP_PASS_FIRST), int'(OP_PASS_LAST)));
      row.a = rand_operand();
      // Equal operands now and then, so compare and sub hit the tie.
      row.b = ($urandom_range(0, 7) == 0) ? row.a : rand_operand();
      row.cin = 1'($urandom);
      send_op(row);
    end
  endtask

  task automatic check_field(string name, logic [W-1:0] want, logic [W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Each accepted result is checked against the oldest expected item.
  always @(posedge clk) begin : result_check
    alu_flags_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expected item pending: word %h", result_word);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_word", want.word, result_word);
        check_field("carry_out", W'(want.carry), W'(carry_out));
        check_field("overflow_flag", W'(want.ovf), W'(overflow_flag));
        check_field("zero_flag", W'(want.zero), W'(zero_flag));
        check_field("negative_flag", W'(want.neg), W'(negative_flag));
        results_checked++;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners with a free-flowing pipe.
    foreach (DIRECTED_OPS[i])
      send_op(DIRECTED_OPS[i]);

    // Random items under each idling mix.
    send_random(RANDOM_PER_PHASE);
    send_idle_pct = 70;
    send_random(RANDOM_PER_PHASE);
    send_idle_pct = 0;
    recv_stall_pct = 70;
    send_random(RANDOM_PER_PHASE);
    send_idle_pct = 14;
    recv_stall_pct = 14;
    send_random(RANDOM_PER_PHASE);

    // Back-pressure: receiver holds off while items keep coming, so the
    // three stages fill and in_ready has to drop.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_left <= HOLD_OFF_CYCLES;
    send_random(PRESSURE_ITEMS);
    in_valid <= 1'b0;

    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items (%0d directed corners, rest random over four idle mixes",
             items_sent, NUM_DIRECTED);
    $display("and one long output hold-off); %0d results checked, %0d mismatches.",
             results_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
